[sv/svpc_pkg.sv]
`default_nettype none

package svpc_pkg;

   // build-time choices
   localparam int CORDIC_STEPS_DEF = 8;
   localparam int STEP_W           = 3;
   localparam int ANGLE_STEPS      = 1024;
   localparam int ANG_W            = 10;
   localparam int LIMIT_RESET      = 500;

   // field widths
   localparam int VOLT_W  = 20;
   localparam int PHASE_W = 10;
   localparam int DRIVE_W = 12;
   localparam int LIMIT_W = 10;

   // datapath widths
   localparam int XY_W     = 23;
   localparam int GAIN_W   = 10;
   localparam int PROD_W   = 32;
   localparam int MAG_W    = 10;
   localparam int SIN_W    = 12;
   localparam int SIN_IDX_W = 8;
   localparam int SIN_DEPTH = 172;

   // projection addressing: offset inside a sector runs up to its width
   localparam logic [SIN_IDX_W-1:0] REL_MAX   = 8'd171;
   localparam logic [SIN_IDX_W-1:0] R1_ORIGIN = 8'd170;

   localparam logic [7:0] STEP_ANGLE [0:7] = '{
      8'd128, 8'd76, 8'd40, 8'd20, 8'd10, 8'd5, 8'd3, 8'd1};

   localparam logic [GAIN_W-1:0] STEP_GAIN [0:7] = '{
      10'd724, 10'd648, 10'd628, 10'd623, 10'd623, 10'd622, 10'd622, 10'd622};

   typedef logic signed [SIN_W-1:0] sin_table_type [0:SIN_DEPTH-1];

   // controller to datapath
   typedef struct packed {
      logic load;
      logic rotate;
      logic scale;
      logic limit;
      logic project;
      logic write;
   } svpc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rot_last;
   } svpc_status_type;

   // start angle of each sector
   function automatic logic [ANG_W-1:0] sector_base(input logic [2:0] sec);
      logic [ANG_W-1:0] base;
      case (sec)
         3'd0:    base = 10'd0;
         3'd1:    base = 10'd170;
         3'd2:    base = 10'd341;
         3'd3:    base = 10'd512;
         3'd4:    base = 10'd682;
         default: base = 10'd853;
      endcase
      return base;
   endfunction

   // round(1024*cos(2*pi*j/1024)) by a q30 taylor series, evaluated at elaboration
   function automatic longint cos_quadrant(input longint j);
      longint x;
      longint x2;
      longint term;
      longint sum;
      x    = (64'sd3373259426 * j * 2 + 64'sd512) >> 10;
      x2   = (x * x) >> 30;
      term = 64'sd1 << 30;
      sum  = term;
      term = ((term * x2) >> 30) / 2;   sum = sum - term;
      term = ((term * x2) >> 30) / 12;  sum = sum + term;
      term = ((term * x2) >> 30) / 30;  sum = sum - term;
      term = ((term * x2) >> 30) / 56;  sum = sum + term;
      term = ((term * x2) >> 30) / 90;  sum = sum - term;
      term = ((term * x2) >> 30) / 132; sum = sum + term;
      term = ((term * x2) >> 30) / 182; sum = sum - term;
      term = ((term * x2) >> 30) / 240; sum = sum + term;
      term = ((term * x2) >> 30) / 306; sum = sum - term;
      term = ((term * x2) >> 30) / 380; sum = sum + term;
      if (sum < 0) begin
         sum = 0;
      end
      return (sum + (64'sd1 << 19)) >> 20;
   endfunction

   // sine of k steps, k in 0..171
   function automatic sin_table_type build_sin_table();
      sin_table_type tbl;
      for (int k = 0; k < SIN_DEPTH; k++) begin
         tbl[k] = SIN_W'(cos_quadrant(longint'(ANGLE_STEPS / 4 - k)));
      end
      return tbl;
   endfunction

   localparam sin_table_type SIN_TABLE = build_sin_table();

endpackage

`default_nettype wire

[sv/svpc_ctrl.sv]
`default_nettype none

module svpc_ctrl
   import svpc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire svpc_status_type status,
   output svpc_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_SCALE,
      ST_LIMIT,
      ST_PROJECT,
      ST_WRITE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // command decode and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            if (status.rot_last) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_LIMIT;
         end
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            state_in  = ST_PROJECT;
         end
         ST_PROJECT: begin
            cmd.project = 1'b1;
            state_in    = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word flag
   always_comb begin
      if (cmd.write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // a waiting word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (!rsp_valid_ff || rsp_tready))
      else $error("result word overwritten while waiting");

   // an accepted word starts the rotation loop
   a_accept_rotate: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_ROTATE))
      else $error("accepted word did not start rotation");

   // one datapath command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.rotate, cmd.scale, cmd.limit, cmd.project, cmd.write}))
      else $error("more than one datapath command");

   // scaling only follows the last rotation
   a_scale_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> ($past(cmd.rotate) && $past(status.rot_last)))
      else $error("scaling entered before rotation finished");

endmodule

`default_nettype wire

[sv/svpc_datapath.sv]
`default_nettype none

module svpc_datapath
   import svpc_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire svpc_cmd_type              cmd,
   output svpc_status_type                status,
   input  wire logic signed [VOLT_W-1:0]  volt_d,
   input  wire logic signed [VOLT_W-1:0]  volt_q,
   input  wire logic [PHASE_W-1:0]        rotor_phase,
   input  wire logic                      csr_write,
   input  wire logic [LIMIT_W-1:0]        csr_data,
   output logic signed [DRIVE_W-1:0]      phase_a,
   output logic signed [DRIVE_W-1:0]      phase_b,
   output logic signed [DRIVE_W-1:0]      phase_c,
   output logic                           limited
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   logic [LIMIT_W-1:0]         limit_ff;
   logic [LIMIT_W-1:0]         limit_in;
   logic signed [XY_W-1:0]     x_ff, x_in;
   logic signed [XY_W-1:0]     y_ff, y_in;
   logic signed [ANG_W-1:0]    ang_ff, ang_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       neg_ff, neg_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [ANG_W-1:0]           phi_ff, phi_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       lim_ff, lim_in;
   logic [2:0]                 sec_ff, sec_in;
   logic [SIN_IDX_W-1:0]       rel_ff, rel_in;
   logic signed [DRIVE_W-1:0]  r1_ff, r1_in;
   logic signed [DRIVE_W-1:0]  r2_ff, r2_in;
   logic signed [DRIVE_W-1:0]  a_ff, a_in;
   logic signed [DRIVE_W-1:0]  b_ff, b_in;
   logic signed [DRIVE_W-1:0]  c_ff, c_in;
   logic                       limited_ff, limited_in;

   logic signed [XY_W-1:0]     vd_ext;
   logic signed [XY_W-1:0]     x_sh, y_sh;
   logic signed [XY_W-1:0]     x_rot, y_rot;
   logic signed [ANG_W-1:0]    ang_rot, step_ang;
   logic                       rot_pos;
   logic signed [ANG_W:0]      ang_ext, ang_fix;
   logic [DRIVE_W-1:0]         mag_raw;
   logic [12:0]                phi6;
   logic [ANG_W-1:0]           rel_full;
   logic [SIN_IDX_W-1:0]       idx1;
   logic signed [SIN_W-1:0]    sin1, sin2;
   logic signed [22:0]         p1, p2;
   logic signed [DRIVE_W:0]    r1e, r2e;
   logic signed [DRIVE_W:0]    sa, sb, sc;

   // one vectoring step on the shared shift and add unit
   always_comb begin
      x_sh     = x_ff >>> step_ff;
      y_sh     = y_ff >>> step_ff;
      rot_pos  = !y_ff[XY_W-1] && (y_ff != '0);
      step_ang = $signed({2'b00, STEP_ANGLE[step_ff]});
      if (rot_pos) begin
         x_rot   = x_ff + y_sh;
         y_rot   = y_ff - x_sh;
         ang_rot = ang_ff + step_ang;
      end else begin
         x_rot   = x_ff - y_sh;
         y_rot   = y_ff + x_sh;
         ang_rot = ang_ff - step_ang;
      end
      status.rot_last = (y_rot == '0) || (step_ff == LAST_STEP);
   end

   // angle fold for negative d axis, then add the rotor phase
   always_comb begin
      ang_ext = {ang_ff[ANG_W-1], ang_ff};
      if (neg_ff) begin
         ang_fix = 11'sd512 - ang_ext;
      end else begin
         ang_fix = ang_ext;
      end
   end

   // sector of the output angle, offset inside it, and the scaled magnitude
   always_comb begin
      phi6     = {1'b0, phi_ff, 2'b00} + {2'b00, phi_ff, 1'b0};
      rel_full = phi_ff - sector_base(phi6[12:10]);
      mag_raw  = prod_ff[PROD_W-1:PROD_W-DRIVE_W];
   end

   // projections onto the two sector edges
   always_comb begin
      if (rel_ff == REL_MAX) begin
         idx1 = SIN_IDX_W'(1);
         sin1 = -SIN_TABLE[idx1];
      end else begin
         idx1 = R1_ORIGIN - rel_ff;
         sin1 = SIN_TABLE[idx1];
      end
      sin2 = SIN_TABLE[rel_ff];
      p1   = $signed({1'b0, mag_ff}) * sin1;
      p2   = $signed({1'b0, mag_ff}) * sin2;
   end

   // sector patterns
   always_comb begin
      r1e = {r1_ff[DRIVE_W-1], r1_ff};
      r2e = {r2_ff[DRIVE_W-1], r2_ff};
      case (sec_ff)
         3'd0: begin
            sa = r1e + r2e;  sb = r2e - r1e;  sc = -r1e - r2e;
         end
         3'd1: begin
            sa = r1e - r2e;  sb = r1e + r2e;  sc = -r1e - r2e;
         end
         3'd2: begin
            sa = -r1e - r2e; sb = r1e + r2e;  sc = r2e - r1e;
         end
         3'd3: begin
            sa = -r1e - r2e; sb = r1e - r2e;  sc = r1e + r2e;
         end
         3'd4: begin
            sa = r2e - r1e;  sb = -r1e - r2e; sc = r1e + r2e;
         end
         default: begin
            sa = r1e + r2e;  sb = -r1e - r2e; sc = r1e - r2e;
         end
      endcase
   end

   // next values under the controller's commands
   always_comb begin
      vd_ext     = XY_W'(volt_d);
      limit_in   = csr_write ? csr_data : limit_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      ang_in     = ang_ff;
      step_in    = step_ff;
      neg_in     = neg_ff;
      phase_in   = phase_ff;
      prod_in    = prod_ff;
      phi_in     = phi_ff;
      mag_in     = mag_ff;
      lim_in     = lim_ff;
      sec_in     = sec_ff;
      rel_in     = rel_ff;
      r1_in      = r1_ff;
      r2_in      = r2_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      limited_in = limited_ff;
      if (cmd.load) begin
         x_in     = volt_d[VOLT_W-1] ? -vd_ext : vd_ext;
         y_in     = XY_W'(volt_q);
         ang_in   = '0;
         step_in  = '0;
         neg_in   = volt_d[VOLT_W-1];
         phase_in = rotor_phase;
      end
      if (cmd.rotate) begin
         x_in   = x_rot;
         y_in   = y_rot;
         ang_in = ang_rot;
         if (!status.rot_last) begin
            step_in = step_ff + 1'b1;
         end
      end
      if (cmd.scale) begin
         prod_in = {{(PROD_W-GAIN_W){1'b0}}, STEP_GAIN[step_ff]}
                 * {{(PROD_W-XY_W+1){1'b0}}, x_ff[XY_W-2:0]};
         phi_in  = phase_ff + ang_fix[ANG_W-1:0];
      end
      if (cmd.limit) begin
         if (mag_raw > {{(DRIVE_W-LIMIT_W){1'b0}}, limit_ff}) begin
            mag_in = limit_ff;
            lim_in = 1'b1;
         end else begin
            mag_in = mag_raw[MAG_W-1:0];
            lim_in = 1'b0;
         end
         sec_in = phi6[12:10];
         rel_in = rel_full[SIN_IDX_W-1:0];
      end
      if (cmd.project) begin
         r1_in = p1[21:10];
         r2_in = p2[21:10];
      end
      if (cmd.write) begin
         a_in       = sa[DRIVE_W-1:0];
         b_in       = sb[DRIVE_W-1:0];
         c_in       = sc[DRIVE_W-1:0];
         limited_in = lim_ff;
      end
   end

   // magnitude limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_W'(LIMIT_RESET);
      end else begin
         limit_ff <= limit_in;
      end
   end

   // working and output registers
   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      ang_ff     <= ang_in;
      step_ff    <= step_in;
      neg_ff     <= neg_in;
      phase_ff   <= phase_in;
      prod_ff    <= prod_in;
      phi_ff     <= phi_in;
      mag_ff     <= mag_in;
      lim_ff     <= lim_in;
      sec_ff     <= sec_in;
      rel_ff     <= rel_in;
      r1_ff      <= r1_in;
      r2_ff      <= r2_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      limited_ff <= limited_in;
   end

   assign phase_a = a_ff;
   assign phase_b = b_ff;
   assign phase_c = c_ff;
   assign limited = limited_ff;

endmodule

`default_nettype wire

[sv/space_vector_pwm_cordic.sv]
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  req_tdata: volt_d, volt_q, rotor_phase
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata: phase_a..c, rsp_tuser: limited
// csr       in         csr_valid/csr_ready    csr_data: magnitude_limit
//
// the vectoring loop runs one step per cycle on one shift/add unit and ends early
// when y reaches zero; a new word is accepted only after the last one is written.
// csr_ready is always high.
// synchronous reset idles the controller, drops rsp_tvalid, sets the limit to 500.
// a result waits in the output register; the next word is accepted and worked
// on, and holds before its write until the waiting word is taken.

module space_vector_pwm_cordic
   import svpc_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // volt_d [19:0], volt_q [39:20], rotor_phase [49:40], zero [55:50]
   input  wire logic [55:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // phase_a [11:0], phase_b [23:12], phase_c [35:24], zero [39:36]
   output logic [39:0]       rsp_tdata,
   // limited [0]
   output logic              rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [9:0]   csr_data
);

   svpc_cmd_type              cmd;
   svpc_status_type           status;
   logic signed [DRIVE_W-1:0] phase_a;
   logic signed [DRIVE_W-1:0] phase_b;
   logic signed [DRIVE_W-1:0] phase_c;
   logic                      limited;

   assign csr_ready = 1'b1;

   // sequencer
   svpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic
   svpc_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .volt_d      (req_tdata[19:0]),
      .volt_q      (req_tdata[39:20]),
      .rotor_phase (req_tdata[49:40]),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .phase_a     (phase_a),
      .phase_b     (phase_b),
      .phase_c     (phase_c),
      .limited     (limited)
   );

   // result packing
   assign rsp_tdata = {4'b0000, phase_c, phase_b, phase_a};
   assign rsp_tuser = limited;

endmodule

`default_nettype wire

[dv/space_vector_pwm_cordic_checker.sv]
`timescale 1ns / 1ps

module space_vector_pwm_cordic_checker
   import svpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // volt_d [19:0], volt_q [39:20], rotor_phase [49:40], zero [55:50]
   input  wire logic [55:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // phase_a [11:0], phase_b [23:12], phase_c [35:24], zero [39:36]
   input  wire logic [39:0] rsp_tdata,
   // limited [0]
   input  wire logic        rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [9:0]  csr_data,
   output int               outstanding,
   output int               fail_count
);

   localparam longint PI_Q30   = 64'sd3373259426;
   localparam longint R1_ANGLE = 7 * 512 / 3;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive_a;
      logic [DRIVE_W-1:0] drive_b;
      logic [DRIVE_W-1:0] drive_c;
      logic               limited;
   } drive_word_type;

   drive_word_type     expected_drive [$];
   drive_word_type     want;
   logic [LIMIT_W-1:0] mag_limit;
   int                 mismatches = 0;

   initial begin
      outstanding = 0;
      fail_count  = 0;
   end

   // arctangent step in angle units
   function automatic longint rot_angle(input int i);
      case (i)
         0:       return 128;
         1:       return 76;
         2:       return 40;
         3:       return 20;
         4:       return 10;
         5:       return 5;
         6:       return 3;
         default: return 1;
      endcase
   endfunction

   // cordic gain correction by number of steps taken
   function automatic longint rot_gain(input int steps);
      case (steps)
         1:       return 724;
         2:       return 648;
         3:       return 628;
         4, 5:    return 623;
         default: return 622;
      endcase
   endfunction

   function automatic longint sector_start(input int sec);
      case (sec)
         0:       return 0;
         1:       return 170;
         2:       return 341;
         3:       return 512;
         4:       return 682;
         default: return 853;
      endcase
   endfunction

   // 1024*cos over the first quadrant, q30 series rounded to an integer
   function automatic longint quarter_cos(input longint j);
      longint x;
      longint x2;
      longint term;
      longint sum;
      x    = (PI_Q30 * j * 2 + 512) / 1024;
      x2   = (x * x) >> 30;
      term = 64'sd1 << 30;
      sum  = term;
      for (int k = 1; k <= 10; k++) begin
         term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
         sum  = (k % 2 == 1) ? sum - term : sum + term;
      end
      if (sum < 0) begin
         sum = 0;
      end
      return (sum + (64'sd1 << 19)) >> 20;
   endfunction

   function automatic longint cos_steps(input longint i);
      longint idx;
      longint r;
      idx = i & 1023;
      r   = idx % 256;
      case (idx / 256)
         0:       return quarter_cos(r);
         1:       return -quarter_cos(256 - r);
         2:       return -quarter_cos(r);
         default: return quarter_cos(256 - r);
      endcase
   endfunction

   function automatic longint sin_steps(input longint a);
      return cos_steps((a + 768) & 1023);
   endfunction

   // phase drives for one command word at the given magnitude limit
   function automatic drive_word_type predict_drive(input logic [55:0] word,
                                                    input logic [LIMIT_W-1:0] limit);
      drive_word_type res;
      longint vd, vq, ph;
      longint x, y, x1, y1, ang, mag, phi, r1, r2, pa, pb, pc;
      int     steps;
      int     sec;
      vd    = longint'($signed(word[19:0]));
      vq    = longint'($signed(word[39:20]));
      ph    = longint'(word[49:40]);
      x     = (vd < 0) ? -vd : vd;
      y     = vq;
      ang   = 0;
      steps = 0;
      res.limited = 1'b0;

      // vectoring, y <= 0 rotates the negative way, stop once y hits zero
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         x1 = x;
         y1 = y;
         steps++;
         if (y1 > 0) begin
            x   = x1 + (y1 >>> i);
            y   = y1 - (x1 >>> i);
            ang = ang + rot_angle(i);
         end else begin
            x   = x1 - (y1 >>> i);
            y   = y1 + (x1 >>> i);
            ang = ang - rot_angle(i);
         end
         if (y == 0) begin
            break;
         end
      end
      if (vd < 0) begin
         ang = 512 - ang;
      end
      if (ang < 0) begin
         ang = ang + 1024;
      end

      // gain, scale down and clamp
      mag = (rot_gain(steps) * x) >>> 10;
      mag = mag >>> 10;
      if (mag > longint'(limit)) begin
         mag         = longint'(limit);
         res.limited = 1'b1;
      end

      // sector and the two projections
      phi = (ph + ang) & 1023;
      sec = int'((phi * 6) >> 10);
      if (sec > 5) begin
         sec = 5;
      end
      phi = phi - sector_start(sec);
      r1  = (mag * sin_steps(R1_ANGLE - phi)) >>> 10;
      r2  = (mag * sin_steps(phi)) >>> 10;

      case (sec)
         0: begin
            pa = r1 + r2;  pb = -r1 + r2; pc = -r1 - r2;
         end
         1: begin
            pa = r1 - r2;  pb = r1 + r2;  pc = -r1 - r2;
         end
         2: begin
            pa = -r1 - r2; pb = r1 + r2;  pc = -r1 + r2;
         end
         3: begin
            pa = -r1 - r2; pb = r1 - r2;  pc = r1 + r2;
         end
         4: begin
            pa = -r1 + r2; pb = -r1 - r2; pc = r1 + r2;
         end
         default: begin
            pa = r1 + r2;  pb = -r1 - r2; pc = r1 - r2;
         end
      endcase
      res.drive_a = DRIVE_W'(pa);
      res.drive_b = DRIVE_W'(pb);
      res.drive_c = DRIVE_W'(pc);
      return res;
   endfunction

   task automatic check_field(input string field, input logic [DRIVE_W-1:0] exp_val,
                              input logic [DRIVE_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t mismatch %s: expected %0d, actual %0d", $time, field,
                  $signed(exp_val), $signed(got_val));
         mismatches++;
      end
   endtask

   // track the limit, predict on each command word, compare each drive word
   always @(posedge clock) begin
      if (reset) begin
         mag_limit = LIMIT_W'(LIMIT_RESET);
         expected_drive.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            mag_limit = csr_data;
         end
         if (req_tvalid && req_tready) begin
            expected_drive.push_back(predict_drive(req_tdata, mag_limit));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_drive.size() == 0) begin
               $display("%0t unexpected drive word: expected none, actual %h/%b",
                        $time, rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               want = expected_drive.pop_front();
               check_field("phase_a", want.drive_a, rsp_tdata[11:0]);
               check_field("phase_b", want.drive_b, rsp_tdata[23:12]);
               check_field("phase_c", want.drive_c, rsp_tdata[35:24]);
               check_field("limited", {11'd0, want.limited}, {11'd0, rsp_tuser});
            end
         end
      end
      outstanding <= expected_drive.size();
      fail_count  <= mismatches;
   end

endmodule

[dv/space_vector_pwm_cordic_tb.sv]
`timescale 1ns / 1ps

module space_vector_pwm_cordic_tb;

   localparam int IDLE_LIMIT    = 1000;
   localparam int TAIL_CYCLES   = 20;
   localparam int LIMIT_PHASES  = 8;
   localparam int PHASE_WORDS   = 100;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [55:0] req_tdata  = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [39:0] rsp_tdata;
   wire         rsp_tuser;
   logic        csr_valid  = 1'b0;
   wire         csr_ready;
   logic [9:0]  csr_data   = '0;

   int outstanding;
   int fail_count;
   int idle_cycles = 0;
   bit send_burst  = 1'b0;

   space_vector_pwm_cordic DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   space_vector_pwm_cordic_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // wait until every drive word has been taken
   task automatic wait_drained();
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_limit(input logic [9:0] value);
      wait_drained();
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one command word, with a random gap unless bursting
   task automatic send_command(input logic [19:0] vd, input logic [19:0] vq,
                               input logic [9:0] ph);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {6'd0, ph, vq, vd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // voltage mix: full range, small magnitudes of either sign, extremes
   function automatic logic [19:0] draw_volt();
      logic [19:0] v;
      int          span;
      span = $urandom_range(1, 19);
      case ($urandom_range(0, 5))
         0, 1, 2: v = 20'($urandom);
         3, 4: begin
            v = 20'($urandom_range(0, (1 << span) - 1));
            if ($urandom_range(0, 1) == 1) begin
               v = -v;
            end
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       v = 20'h7FFFF;
               1:       v = 20'h80000;
               2:       v = 20'hFFFFF;
               default: v = 20'h00000;
            endcase
         end
      endcase
      return v;
   endfunction

   // result side: random stalls, with bursts of no stall
   initial begin
      int stall;
      int taken;
      bit take_burst;
      taken      = 0;
      take_burst = 1'b0;
      @(posedge clock);
      forever begin
         stall = take_burst ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if (taken % 32 == 0) begin
            take_burst = ($urandom_range(0, 2) == 0);
         end
      end
   end

   // watchdog on cycles with no word moving on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [19:0] vd;
      logic [19:0] vq;
      logic [9:0]  limit;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset limit
      send_command(20'd0, 20'd0, 10'd0);                 // zero vector
      send_command(20'd0, 20'd0, 10'd1023);
      send_command(20'h7FFFF, 20'd0, 10'd0);             // y zero at start
      send_command(20'h80000, 20'd0, 10'd1023);          // negative d, y zero
      send_command(20'h7FFFF, 20'h7FFFF, 10'd512);       // clamped
      send_command(20'h80000, 20'h80000, 10'd256);
      send_command(20'h7FFFF, 20'h80000, 10'd100);
      send_command(20'h80000, 20'h7FFFF, 10'd900);
      send_command(20'd1, 20'd1, 10'd0);                 // y reaches zero at once
      send_command(20'hFFFFF, 20'd1, 10'd170);
      send_command(20'd1, 20'hFFFFF, 10'd171);           // negative angle wraps
      send_command(20'hFFFFF, 20'hFFFFF, 10'd341);
      send_command(20'd1000, 20'd1000, 10'd682);
      send_command(20'd1000, -20'd1000, 10'd853);
      send_command(-20'd1000, 20'd0, 10'd852);
      send_command(20'd0, 20'd1000, 10'd300);
      send_command(20'd0, -20'd1000, 10'd700);
      send_command(20'd3000, 20'd1000, 10'd1);
      send_command(20'd400000, 20'd10, 10'd600);         // just under the limit
      send_command(-20'd300000, 20'd200000, 10'd169);
      send_command(20'd500000, 20'hFFFFF, 10'd511);
      send_command(20'd7, 20'd3, 10'd1022);
      req_tvalid <= 1'b0;

      // random words over several limits, extremes included
      for (int p = 0; p < LIMIT_PHASES; p++) begin
         case (p)
            0:                limit = 10'd1023;
            1:                limit = 10'd0;
            2:                limit = 10'd1;
            3:                limit = 10'd500;
            LIMIT_PHASES - 1: limit = 10'd1023;
            default:          limit = 10'($urandom_range(0, 1023));
         endcase
         write_limit(limit);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 25 == 0) begin
               send_burst = ($urandom_range(0, 3) == 0);
            end
            // hold off now and then until the pipe is empty
            if ($urandom_range(0, 49) == 0) begin
               req_tvalid <= 1'b0;
               wait_drained();
            end
            vd = draw_volt();
            vq = draw_volt();
            // equal and opposite axes end the rotation early, single axes are drawn too
            case ($urandom_range(0, 9))
               0:       vq = vd;
               1:       vq = -vd;
               2:       vq = 20'd0;
               3:       vd = 20'd0;
               default: ;
            endcase
            send_command(vd, vq, 10'($urandom_range(0, 1023)));
         end
         req_tvalid <= 1'b0;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
